>>> rtl/keyboard_scancode_fifo_macros.svh
// Assertion macros for the keyboard scancode FIFO.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef KEYBOARD_SCANCODE_FIFO_MACROS_SVH
`define KEYBOARD_SCANCODE_FIFO_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define KSF_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyboard_scancode_fifo: check failed");
// Next-cycle implication, disabled while reset is low.
`define KSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyboard_scancode_fifo: check failed");
`else
`define KSF_ASSERT(label, clk, rst_n, ante, cons)
`define KSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ksf_pkg.sv
// Shared types, constants and the scancode decode table of the keyboard FIFO.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ksf_pkg;

  // Default depth of the character store; it holds one fewer entry.
  localparam int QUEUE_DEPTH_DEF = 128;
  // Fill level saturates at this value.
  localparam int FILL_MAX = 127;
  // Depth of the request queue between front and back (a power of two).
  localparam int OPQ_DEPTH = 2;
  // Bit of a set-1 scancode that marks a release.
  localparam int RELEASE_BIT = 7;

  // Request kinds handed from front to back.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] scancode;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] character;
    logic       queue_empty;
    logic       overflow_seen;
    logic [6:0] fill_level;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
  } op_t;

  // Set-1 make code to ASCII; zero means the code has no mapping.
  function automatic logic [6:0] map_code(input logic [7:0] code);
    logic [6:0] c;
    unique case (code)
      8'h02: c = 7'h31;
      8'h03: c = 7'h32;
      8'h04: c = 7'h33;
      8'h05: c = 7'h34;
      8'h06: c = 7'h35;
      8'h07: c = 7'h36;
      8'h08: c = 7'h37;
      8'h09: c = 7'h38;
      8'h0A: c = 7'h39;
      8'h0B: c = 7'h30;
      8'h0C: c = 7'h2D;
      8'h0D: c = 7'h3D;
      8'h0E: c = 7'h08;
      8'h10: c = 7'h71;
      8'h11: c = 7'h77;
      8'h12: c = 7'h65;
      8'h13: c = 7'h72;
      8'h14: c = 7'h74;
      8'h15: c = 7'h79;
      8'h16: c = 7'h75;
      8'h17: c = 7'h69;
      8'h18: c = 7'h6F;
      8'h19: c = 7'h70;
      8'h1C: c = 7'h0A;
      8'h1E: c = 7'h61;
      8'h1F: c = 7'h73;
      8'h20: c = 7'h64;
      8'h21: c = 7'h66;
      8'h22: c = 7'h67;
      8'h23: c = 7'h68;
      8'h24: c = 7'h6A;
      8'h25: c = 7'h6B;
      8'h26: c = 7'h6C;
      8'h27: c = 7'h3B;
      8'h28: c = 7'h27;
      8'h2C: c = 7'h7A;
      8'h2D: c = 7'h78;
      8'h2E: c = 7'h63;
      8'h2F: c = 7'h76;
      8'h30: c = 7'h62;
      8'h31: c = 7'h6E;
      8'h32: c = 7'h6D;
      8'h33: c = 7'h2C;
      8'h34: c = 7'h2E;
      8'h35: c = 7'h2F;
      8'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/keyboard_scancode_fifo.sv
// Channel  Signals                          Direction  Content
// in       in_valid, in_ready, in_data      input      mode, scancode
// out      out_valid, out_ready, out_data   output     one status/character result
//
// Every accepted item yields exactly one result, in order. A push, a no-op and a
// pop of an empty queue go straight to the result register in the back end; a pop
// that returns a character first passes the registered read port of the character store.
// A two-entry request queue lets inputs be taken while the result waits.
// Reset is synchronous; the store is not cleared, only pointers, flag, state and valid.
// Top level of the keyboard scancode FIFO; uses ksf_pkg, ksf_front, ksf_opq, ksf_back.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_fifo import ksf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_ready,
  output out_t out_data
);

  logic fq_valid;
  logic fq_ready;
  op_t  fq_data;
  logic qb_valid;
  logic qb_ready;
  op_t  qb_data;

  // Classify incoming items.
  ksf_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (fq_valid),
    .op_ready (fq_ready),
    .op_data  (fq_data)
  );

  // Buffer requests between the two halves.
  ksf_opq u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Execute requests against the character store.
  ksf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (qb_valid),
    .op_ready  (qb_ready),
    .op_data   (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/ksf_front.sv
// Front end: accepts input items and classifies each one as push, pop or no-op.
// Depends on ksf_pkg for the item types, request codes and the decode table.
`timescale 1ns / 1ps
`default_nettype none

module ksf_front import ksf_pkg::*; (
  input  wire  in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic op_valid,
  input  wire  op_ready,
  output op_t  op_data
);

  logic [6:0] ascii;

  // Decode the scancode; release codes never map.
  always_comb begin
    ascii = map_code(in_data.scancode);
    op_data.ch = ascii;
    if (in_data.mode) begin
      op_data.kind = OP_POP;
    end else if (!in_data.scancode[RELEASE_BIT] && (ascii != 7'h00)) begin
      op_data.kind = OP_PUSH;
    end else begin
      op_data.kind = OP_NONE;
    end
  end

  // Requests flow straight into the queue; it alone applies backpressure.
  assign op_valid = in_valid;
  assign in_ready = op_ready;

endmodule

`default_nettype wire

>>> rtl/ksf_opq.sv
// Short request queue that decouples the front end from the back end.
// Depends on ksf_pkg for the request type and its depth.
`timescale 1ns / 1ps
`default_nettype none

module ksf_opq import ksf_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  wr_valid,
  output logic wr_ready,
  input  op_t  wr_data,
  output logic rd_valid,
  input  wire  rd_ready,
  output op_t  rd_data
);

  localparam int Aw = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int Cw = $clog2(OPQ_DEPTH + 1);

  op_t           entries_r [OPQ_DEPTH];
  logic [Aw-1:0] wr_ptr_r;
  logic [Aw-1:0] rd_ptr_r;
  logic [Cw-1:0] count_r;
  logic          wr_fire;
  logic          rd_fire;

  assign wr_ready = (count_r != Cw'(OPQ_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entries_r[rd_ptr_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr_r <= wr_ptr_r + Aw'(1);
      end
      if (rd_fire) begin
        rd_ptr_r <= rd_ptr_r + Aw'(1);
      end
      if (wr_fire && !rd_fire) begin
        count_r <= count_r + Cw'(1);
      end else if (rd_fire && !wr_fire) begin
        count_r <= count_r - Cw'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ksf_back.sv
// Back end: owns the character store, its pointers and the overflow flag,
// carries out each request and registers one result for it. Uses ksf_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_scancode_fifo_macros.svh"

module ksf_back import ksf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  op_valid,
  output logic op_ready,
  input  op_t  op_data,
  output logic out_valid,
  input  wire  out_ready,
  output out_t out_data
);

  localparam int Aw = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic [6:0]    store_r [QUEUE_DEPTH];
  logic [6:0]    rd_data_r;
  logic [Aw-1:0] wp_r;
  logic [Aw-1:0] wp_nxt;
  logic [Aw-1:0] rp_r;
  logic [Aw-1:0] rp_nxt;
  logic          lost_r;
  logic          lost_nxt;
  logic          state_r;
  logic          state_nxt;
  logic          out_valid_r;
  out_t          out_r;
  out_t          res;
  logic          op_fire;
  logic          mem_we;
  logic          rd_en;
  logic          out_we;
  logic          char_sel;
  logic [Aw:0]   fill;

  function automatic logic [Aw-1:0] advance(input logic [Aw-1:0] p);
    return (p == Aw'(QUEUE_DEPTH - 1)) ? '0 : p + Aw'(1);
  endfunction

  assign op_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign op_fire   = op_valid && op_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Request execution and pointer updates.
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    lost_nxt  = lost_r;
    state_nxt = state_r;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    out_we    = 1'b0;
    char_sel  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (op_fire) begin
          out_we = 1'b1;
          case (op_data.kind)
            OP_PUSH: begin
              if (advance(wp_r) == rp_r) begin
                lost_nxt = 1'b1;
              end else begin
                mem_we = 1'b1;
                wp_nxt = advance(wp_r);
              end
            end
            OP_POP: begin
              // A pop with data waits in ST_RD for the registered read.
              if (wp_r != rp_r) begin
                rd_en     = 1'b1;
                rp_nxt    = advance(rp_r);
                out_we    = 1'b0;
                state_nxt = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        out_we    = 1'b1;
        char_sel  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Status after the step, taken from the updated pointers.
  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      fill = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      fill = {1'b0, wp_nxt} + (Aw + 1)'(QUEUE_DEPTH) - {1'b0, rp_nxt};
    end
    res.char_valid    = char_sel;
    res.character     = char_sel ? rd_data_r : 7'h00;
    res.queue_empty   = (wp_nxt == rp_nxt);
    res.overflow_seen = lost_nxt;
    if (32'(fill) > 32'(FILL_MAX)) begin
      res.fill_level = 7'(FILL_MAX);
    end else begin
      res.fill_level = 7'(fill);
    end
  end

  // Character store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[wp_r] <= op_data.ch;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rp_r];
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (out_we) begin
      out_r <= res;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      lost_r      <= 1'b0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      lost_r  <= lost_nxt;
      state_r <= state_nxt;
      if (out_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pointers stay inside the store.
  `KSF_ASSERT(a_ptr_range, clk, rst_n, 1'b1, (32'(wp_r) < 32'(QUEUE_DEPTH)) && (32'(rp_r) < 32'(QUEUE_DEPTH)))
  // The overflow flag is sticky.
  `KSF_ASSERT_NEXT(a_lost_sticky, clk, rst_n, lost_r, lost_r)
  // A pop waiting on the read never finds the result register occupied.
  `KSF_ASSERT(a_rd_out_free, clk, rst_n, state_r == ST_RD, !out_valid_r)
  // The read cycle always delivers a character.
  `KSF_ASSERT_NEXT(a_rd_delivers, clk, rst_n, state_r == ST_RD, out_valid_r && out_r.char_valid)

endmodule

`default_nettype wire

>>> dv/keyboard_scancode_fifo_tb.sv
// Self-checking testbench for keyboard_scancode_fifo: scancode pushes and character pops.
// Depends on ksf_pkg for the request and result types; needs nothing else but the RTL.
`timescale 1ns / 1ps

module keyboard_scancode_fifo_tb;
  import ksf_pkg::*;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam logic [6:0] ASCII_BS    = 7'h08;
  localparam logic [6:0] ASCII_LF    = 7'h0A;
  localparam logic [6:0] ASCII_SPACE = 7'h20;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  // One directed request, with the result typed in where it is obvious.
  typedef struct packed {
    in_t  req;
    logic typed;
    out_t want;
  } key_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Sideband that travels with in_data: a typed-in expected result.
  logic row_typed;
  out_t row_want;

  // Shadow of the character queue.
  logic [6:0]  char_ring [QDEPTH];
  int unsigned wr_idx;
  int unsigned rd_idx;
  logic        keys_lost;

  out_t pending_status [$];
  int   mismatches;
  int   results_seen;
  int   traffic_items;
  int   chars_popped;
  int   keys_dropped;
  int   deepest_fill;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_asked;
  int   hold_done;
  int   quiet_cycles;

  key_row_t directed_rows [24] = '{
    // Pop right after reset, then release and unmapped codes: all leave it empty.
    '{'{MODE_POP,  8'h00}, 1'b1, '{1'b0, 7'h00, 1'b1, 1'b0, 7'd0}},
    '{'{MODE_PUSH, 8'h80}, 1'b1, '{1'b0, 7'h00, 1'b1, 1'b0, 7'd0}},
    '{'{MODE_PUSH, 8'hFF}, 1'b1, '{1'b0, 7'h00, 1'b1, 1'b0, 7'd0}},
    '{'{MODE_PUSH, 8'h00}, 1'b1, '{1'b0, 7'h00, 1'b1, 1'b0, 7'd0}},
    // Space, enter, backspace and the lowest and highest digit codes.
    '{'{MODE_PUSH, 8'h39}, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 7'd1}},
    '{'{MODE_PUSH, 8'h1C}, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 7'd2}},
    '{'{MODE_PUSH, 8'h0E}, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 7'd3}},
    '{'{MODE_PUSH, 8'h02}, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 7'd4}},
    '{'{MODE_PUSH, 8'h0B}, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 7'd5}},
    // Pops come back oldest first; the scancode of a pop is ignored.
    '{'{MODE_POP,  8'hFF}, 1'b1, '{1'b1, ASCII_SPACE, 1'b0, 1'b0, 7'd4}},
    '{'{MODE_POP,  8'h00}, 1'b1, '{1'b1, ASCII_LF, 1'b0, 1'b0, 7'd3}},
    '{'{MODE_POP,  8'h5A}, 1'b1, '{1'b1, ASCII_BS, 1'b0, 1'b0, 7'd2}},
    '{'{MODE_PUSH, 8'h9C}, 1'b1, '{1'b0, 7'h00, 1'b0, 1'b0, 7'd2}},
    '{'{MODE_PUSH, 8'h7F}, 1'b0, '0},
    '{'{MODE_PUSH, 8'h3A}, 1'b0, '0},
    '{'{MODE_PUSH, 8'h10}, 1'b0, '0},
    '{'{MODE_PUSH, 8'h35}, 1'b0, '0},
    '{'{MODE_PUSH, 8'h28}, 1'b0, '0},
    '{'{MODE_POP,  8'h00}, 1'b0, '0},
    '{'{MODE_POP,  8'h01}, 1'b0, '0},
    '{'{MODE_POP,  8'h80}, 1'b0, '0},
    '{'{MODE_POP,  8'h7E}, 1'b0, '0},
    '{'{MODE_POP,  8'h00}, 1'b0, '0},
    // Queue is drained again.
    '{'{MODE_POP,  8'h00}, 1'b1, '{1'b0, 7'h00, 1'b1, 1'b0, 7'd0}}
  };

  keyboard_scancode_fifo dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Set-1 make code to ASCII, by keyboard row; zero when the key is not mapped.
  function automatic logic [6:0] key_to_ascii(input logic [7:0] code);
    string number_row = "1234567890-=";
    string top_row    = "qwertyuiop";
    string home_row   = "asdfghjkl;'";
    string bottom_row = "zxcvbnm,./";
    logic [6:0] ch;
    ch = 7'h00;
    if (code >= 8'h02 && code <= 8'h0D) begin
      ch = 7'(number_row[code - 8'h02]);
    end else if (code >= 8'h10 && code <= 8'h19) begin
      ch = 7'(top_row[code - 8'h10]);
    end else if (code >= 8'h1E && code <= 8'h28) begin
      ch = 7'(home_row[code - 8'h1E]);
    end else if (code >= 8'h2C && code <= 8'h35) begin
      ch = 7'(bottom_row[code - 8'h2C]);
    end else if (code == 8'h0E) begin
      ch = ASCII_BS;
    end else if (code == 8'h1C) begin
      ch = ASCII_LF;
    end else if (code == 8'h39) begin
      ch = ASCII_SPACE;
    end
    return ch;
  endfunction

  // Applies one accepted request to the shadow queue and returns its status.
  function automatic out_t keyboard_step(input in_t req);
    out_t res;
    logic [6:0] ch;
    int unsigned nxt;
    int unsigned held;
    res = '0;
    if (req.mode == MODE_PUSH) begin
      ch = req.scancode[RELEASE_BIT] ? 7'h00 : key_to_ascii(req.scancode);
      if (ch != 7'h00) begin
        nxt = (wr_idx + 1) % QDEPTH;
        if (nxt != rd_idx) begin
          char_ring[wr_idx] = ch;
          wr_idx = nxt;
        end else begin
          keys_lost = 1'b1;
          keys_dropped++;
        end
      end
    end else if (wr_idx != rd_idx) begin
      res.char_valid = 1'b1;
      res.character = char_ring[rd_idx];
      rd_idx = (rd_idx + 1) % QDEPTH;
    end
    held = (wr_idx + QDEPTH - rd_idx) % QDEPTH;
    res.queue_empty = (wr_idx == rd_idx);
    res.overflow_seen = keys_lost;
    res.fill_level = (held > FILL_MAX) ? 7'(FILL_MAX) : 7'(held);
    return res;
  endfunction

  function automatic logic [7:0] random_mapped_code();
    logic [7:0] code;
    code = 8'($urandom_range(8'h02, 8'h39));
    while (key_to_ascii(code) == 7'h00) code = 8'($urandom_range(8'h02, 8'h39));
    return code;
  endfunction

  // Mostly mapped keys, some releases of mapped keys, some arbitrary bytes.
  function automatic in_t random_request(input int pop_pct);
    in_t req;
    int pick;
    req.mode = ($urandom_range(0, 99) < pop_pct) ? MODE_POP : MODE_PUSH;
    pick = $urandom_range(0, 99);
    if (req.mode == MODE_POP || pick >= 88) begin
      req.scancode = 8'($urandom_range(0, 255));
    end else if (pick >= 75) begin
      req.scancode = random_mapped_code() | 8'h80;
    end else begin
      req.scancode = random_mapped_code();
    end
    return req;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(input string field, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                results_seen, field, got, want));
    end
  endtask

  // Presents one request and waits for it to be taken.
  task automatic offer(input in_t req, input logic typed, input out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= req;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_ready);
    traffic_items++;
  endtask

  task automatic push_key(input logic [7:0] code);
    offer('{MODE_PUSH, code}, 1'b0, '0);
  endtask

  // Random traffic whose pop rate swings so the queue rises and falls.
  task automatic random_mix(input int target);
    int pop_pct;
    int seg_left;
    seg_left = 0;
    pop_pct = 50;
    while (traffic_items < target) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 15;
          1: pop_pct = 50;
          default: pop_pct = 85;
        endcase
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      offer(random_request(pop_pct), 1'b0, '0);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Result sink: random stalls, plus long hold-offs on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    hold_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Records each accepted request, checks each accepted result, and watches for stalls.
  always @(posedge clk) begin : scoreboard
    out_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      moved = 1'b1;
      want = keyboard_step(in_data);
      if (row_typed) want = row_want;
      pending_status.push_back(want);
      if (int'(want.fill_level) > deepest_fill) deepest_fill = int'(want.fill_level);
    end
    if (rst_n && out_valid && out_ready) begin
      moved = 1'b1;
      results_seen++;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_status.pop_front();
        if (want.char_valid) chars_popped++;
        compare_field("char_valid", out_data.char_valid, want.char_valid);
        compare_field("character", out_data.character, want.character);
        compare_field("queue_empty", out_data.queue_empty, want.queue_empty);
        compare_field("overflow_seen", out_data.overflow_seen, want.overflow_seen);
        compare_field("fill_level", out_data.fill_level, want.fill_level);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_status.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    mismatches = 0;
    results_seen = 0;
    traffic_items = 0;
    chars_popped = 0;
    keys_dropped = 0;
    deepest_fill = 0;
    quiet_cycles = 0;
    wr_idx = 0;
    rd_idx = 0;
    keys_lost = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 53;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    row_typed  <= 1'b0;
    row_want   <= '0;
    hold_asked <= 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests.
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // Fill the queue past capacity so keys are lost, with a few releases mixed in.
    repeat (QDEPTH + 6) begin
      if ($urandom_range(0, 7) == 0) push_key(random_mapped_code() | 8'h80);
      push_key(random_mapped_code());
    end

    // Long receiver hold-off while requests keep coming, then a full pause.
    hold_asked <= hold_asked + 1;
    repeat (24) push_key(random_mapped_code());
    wait_all_results();

    // Drain completely and pop past empty.
    repeat (QDEPTH + 2) offer('{MODE_POP, 8'($urandom_range(0, 255))}, 1'b0, '0);
    random_mix(400);

    send_idle_pct = 53;
    recv_idle_pct = 36;
    random_mix(725);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_mix(1050);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_status.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
    end

    $display("Checked %0d results: %0d characters popped, %0d keys lost to a full queue.",
             results_seen, chars_popped, keys_dropped);
    $display("Deepest fill %0d of %0d, %0d mismatches.", deepest_fill, QDEPTH - 1, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
